// ----- rtl/sht1x_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sht1x_pkg;

  // widths fixed by the line protocol
  localparam int unsigned WaitCountBits = 16;
  localparam int unsigned ResetClocks   = 9;

  // configuration register indexes
  localparam logic [1:0] CfgTempCmd  = 2'd0;
  localparam logic [1:0] CfgHumiCmd  = 2'd1;
  localparam logic [1:0] CfgResetCmd = 2'd2;
  localparam logic [1:0] CfgWaitLim  = 2'd3;

  // opcodes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpTemp  = 2'd1;
  localparam logic [1:0] OpHumi  = 2'd2;
  localparam logic [1:0] OpReset = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0]               TempCmdReset  = 8'd3;
  localparam logic [7:0]               HumiCmdReset  = 8'd5;
  localparam logic [7:0]               ResetCmdReset = 8'd30;
  localparam logic [WaitCountBits-1:0] WaitLimReset  = '1;

  // input word
  typedef struct packed {
    logic [1:0] opcode;
    logic       data_in;
  } in_t;

  // result word
  typedef struct packed {
    logic        sck_level;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] reading;
    logic [7:0]  checksum;
    logic [1:0]  error_count;
  } out_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [7:0]               temp_command;
    logic [7:0]               humi_command;
    logic [7:0]               reset_command;
    logic [WaitCountBits-1:0] wait_limit;
  } cfg_t;

  // transmission start pattern, one entry per tick
  function automatic logic ts_sck(input logic [2:0] idx);
    logic [7:0] pat;
    pat = 8'b0001_1011;
    return pat[idx];
  endfunction

  function automatic logic ts_dat(input logic [2:0] idx);
    logic [7:0] pat;
    pat = 8'b1111_0001;
    return pat[idx];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sht1x_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sht1x_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire sht1x_pkg::in_t   in_word_i,
  input  wire sht1x_pkg::cfg_t  cfg_i,
  output sht1x_pkg::out_t       res_o
);

  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhCrHi = 5'd1;
  localparam logic [4:0] PhCrLo = 5'd2;
  localparam logic [4:0] PhTs   = 5'd3;
  localparam logic [4:0] PhWbLo = 5'd4;
  localparam logic [4:0] PhWbHi = 5'd5;
  localparam logic [4:0] PhWait = 5'd6;
  localparam logic [4:0] PhRbLo = 5'd7;
  localparam logic [4:0] PhRbHi = 5'd8;
  localparam logic [4:0] PhEnd  = 5'd9;

  localparam int unsigned WB = sht1x_pkg::WaitCountBits;

  logic [4:0]    phase_q, phase_d;
  logic [3:0]    bit_q, bit_d;
  logic [1:0]    byte_q, byte_d;
  logic [7:0]    shift_q, shift_d;
  logic [15:0]   value_q, value_d;
  logic [7:0]    check_q, check_d;
  logic [WB-1:0] wait_q, wait_d;
  logic [1:0]    err_q, err_d;
  logic [1:0]    op_q, op_d;
  logic          sck, dat, done;
  logic [WB-1:0] wait_inc;

  // saturating error increment
  function automatic logic [1:0] err_inc(input logic [1:0] e);
    return (e == 2'd3) ? e : e + 2'd1;
  endfunction

  assign wait_inc = (wait_q == {WB{1'b1}}) ? wait_q : wait_q + 1'b1;

  // one tick of the line sequencer
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    value_d = value_q;
    check_d = check_q;
    wait_d  = wait_q;
    err_d   = err_q;
    op_d    = op_q;
    sck     = 1'b0;
    dat     = 1'b1;
    done    = 1'b0;
    case (phase_q)
      PhCrHi: begin
        sck     = 1'b1;
        phase_d = PhCrLo;
      end
      PhCrLo: begin
        bit_d = bit_q + 4'd1;
        if (bit_d >= 4'(sht1x_pkg::ResetClocks)) begin
          bit_d   = '0;
          phase_d = PhTs;
        end else begin
          phase_d = PhCrHi;
        end
      end
      PhTs: begin
        sck = sht1x_pkg::ts_sck(bit_q[2:0]);
        dat = sht1x_pkg::ts_dat(bit_q[2:0]);
        if (bit_q >= 4'd5) begin
          bit_d   = '0;
          phase_d = PhWbLo;
        end else begin
          bit_d = bit_q + 4'd1;
        end
      end
      PhWbLo: begin
        dat     = (bit_q < 4'd8) ? shift_q[7] : 1'b1;
        phase_d = PhWbHi;
      end
      PhWbHi: begin
        dat = (bit_q < 4'd8) ? shift_q[7] : 1'b1;
        sck = 1'b1;
        if (bit_q >= 4'd8) begin
          // command ack check
          if (in_word_i.data_in) err_d = err_inc(err_q);
          bit_d   = '0;
          wait_d  = '0;
          phase_d = (op_q == sht1x_pkg::OpReset) ? PhEnd : PhWait;
        end else begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_q + 4'd1;
          phase_d = PhWbLo;
        end
      end
      PhWait: begin
        if (!in_word_i.data_in) begin
          bit_d   = '0;
          byte_d  = '0;
          phase_d = PhRbLo;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= cfg_i.wait_limit || wait_inc == {WB{1'b1}}) begin
            err_d   = err_inc(err_q);
            bit_d   = '0;
            byte_d  = '0;
            phase_d = PhRbLo;
          end
        end
      end
      PhRbLo: begin
        dat     = (bit_q >= 4'd8) ? (byte_q >= 2'd2) : 1'b1;
        phase_d = PhRbHi;
      end
      PhRbHi: begin
        dat = (bit_q >= 4'd8) ? (byte_q >= 2'd2) : 1'b1;
        sck = 1'b1;
        if (bit_q < 4'd8) begin
          shift_d = {shift_q[6:0], in_word_i.data_in};
          bit_d   = bit_q + 4'd1;
          phase_d = PhRbLo;
        end else begin
          case (byte_q)
            2'd0:    value_d = {shift_q, value_q[7:0]};
            2'd1:    value_d = {value_q[15:8], shift_q};
            default: check_d = shift_q;
          endcase
          bit_d = '0;
          if (byte_q >= 2'd2) begin
            phase_d = PhEnd;
          end else begin
            byte_d  = byte_q + 2'd1;
            phase_d = PhRbLo;
          end
        end
      end
      PhEnd: begin
        done    = 1'b1;
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
        if (in_word_i.opcode != sht1x_pkg::OpTick) begin
          op_d   = in_word_i.opcode;
          err_d  = '0;
          bit_d  = '0;
          byte_d = '0;
          wait_d = '0;
          case (in_word_i.opcode)
            sht1x_pkg::OpTemp: shift_d = cfg_i.temp_command;
            sht1x_pkg::OpHumi: shift_d = cfg_i.humi_command;
            default:           shift_d = cfg_i.reset_command;
          endcase
          phase_d = (in_word_i.opcode == sht1x_pkg::OpReset) ? PhCrHi : PhTs;
        end
      end
    endcase
  end

  // result word for this tick
  always_comb begin
    res_o.sck_level    = sck;
    res_o.data_release = dat;
    res_o.busy_res     = (phase_d != PhIdle);
    res_o.done_res     = done;
    res_o.reading      = value_d;
    res_o.checksum     = check_d;
    res_o.error_count  = err_d;
  end

  // sequencer state, advanced on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      value_q <= '0;
      check_q <= '0;
      wait_q  <= '0;
      err_q   <= '0;
      op_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      value_q <= value_d;
      check_q <= check_d;
      wait_q  <= wait_d;
      err_q   <= err_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sht1x_two_wire_measure_master.sv -----
// Two-wire humidity and temperature sensor master, one line half-period per word.
// Input channel (in_valid_i/in_ready_o/in_word_i): each word is one tick with
// the sampled DATA level and an opcode; the opcode only starts a sequence
// while idle (temperature, humidity or soft reset) and is ignored when busy.
// Output channel (out_valid_o/out_ready_o/out_word_o): exactly one result word
// per input word, carrying SCK and DATA drive for the tick, busy and done
// flags, the stored reading, checksum and error count.
// Each result is captured in the output register at the edge that accepts its
// word. Throughput: one word per cycle; the sequencer advances its
// state in the accepting cycle and the result register hands off on the
// same edge, so input can flow while the receiver takes words.
// Stall: when the receiver holds out_ready_i low the result stays put and
// in_ready_o drops until the result is taken; no word is lost or repeated.
// Config: cfg_we_i writes register cfg_index_i with cfg_data_i at the edge.
// Reset: sequencer idle, stores and error count zero, output register empty,
// command bytes 3/5/30 and wait limit all ones.
`timescale 1ns / 1ps
`default_nettype none

module sht1x_two_wire_measure_master (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sht1x_pkg::in_t  in_word_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output sht1x_pkg::out_t      out_word_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [sht1x_pkg::WaitCountBits-1:0] cfg_data_i
);

  sht1x_pkg::cfg_t cfg_q;
  sht1x_pkg::out_t res;
  sht1x_pkg::out_t out_q;
  logic            out_valid_q;
  logic            step;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_command  <= sht1x_pkg::TempCmdReset;
      cfg_q.humi_command  <= sht1x_pkg::HumiCmdReset;
      cfg_q.reset_command <= sht1x_pkg::ResetCmdReset;
      cfg_q.wait_limit    <= sht1x_pkg::WaitLimReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sht1x_pkg::CfgTempCmd:  cfg_q.temp_command  <= cfg_data_i[7:0];
        sht1x_pkg::CfgHumiCmd:  cfg_q.humi_command  <= cfg_data_i[7:0];
        sht1x_pkg::CfgResetCmd: cfg_q.reset_command <= cfg_data_i[7:0];
        sht1x_pkg::CfgWaitLim:  cfg_q.wait_limit    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sht1x_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= step;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // sequencer phases of the line master
  typedef enum logic [4:0] {
    MstIdle, MstClrHi, MstClrLo, MstStart, MstTxLo, MstTxHi,
    MstWait, MstRxLo, MstRxHi, MstEnd
  } mst_phase_e;

  // one line of the directed script: a word repeated, optionally with a known result
  typedef struct {
    logic [1:0]      op;
    logic            din;
    int              reps;
    bit              known;
    sht1x_pkg::out_t want;
  } script_row_t;

  // transmission start pattern, tick 0 in bit 0
  localparam logic [5:0] StartSck = 6'b011011;
  localparam logic [5:0] StartDat = 6'b110001;
  localparam int         RandomWords = 1500;
  localparam int         NumSettings = 5;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  sht1x_pkg::in_t                      in_word_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  sht1x_pkg::out_t                     out_word_o;
  logic                                cfg_we_i = 1'b0;
  logic [1:0]                          cfg_index_i = sht1x_pkg::CfgTempCmd;
  logic [sht1x_pkg::WaitCountBits-1:0] cfg_data_i = '0;

  // model copy of the master state and its registers
  mst_phase_e                          mst_phase = MstIdle;
  logic [3:0]                          bit_cnt = '0;
  logic [1:0]                          byte_cnt = '0;
  logic [7:0]                          shifter = '0;
  logic [15:0]                         value_q = '0;
  logic [7:0]                          check_q = '0;
  logic [sht1x_pkg::WaitCountBits-1:0] wait_cnt = '0;
  logic [1:0]                          err_q = '0;
  logic [1:0]                          cur_op = sht1x_pkg::OpTick;
  logic [7:0]                          temp_cmd = sht1x_pkg::TempCmdReset;
  logic [7:0]                          humi_cmd = sht1x_pkg::HumiCmdReset;
  logic [7:0]                          rst_cmd = sht1x_pkg::ResetCmdReset;
  logic [sht1x_pkg::WaitCountBits-1:0] wait_lim = sht1x_pkg::WaitLimReset;

  sht1x_pkg::out_t expected_ticks[$];
  int   errors_found = 0;
  int   words_sent = 0;
  int   results_checked = 0;
  int   seqs_done = 0;
  int   seqs_flagged = 0;
  int   wait_left = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   stall_left = 0;

  // directed script, run with the registers at their reset values
  script_row_t script[18] = '{
    '{sht1x_pkg::OpTick,  1'b0, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 2'd0}},
    '{sht1x_pkg::OpTick,  1'b1, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 2'd0}},
    '{sht1x_pkg::OpTemp,  1'b1, 1,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 8'h00, 2'd0}},
    // opcodes during start condition and command are ignored
    '{sht1x_pkg::OpReset, 1'b1, 6,  1'b0, '0},
    '{sht1x_pkg::OpHumi,  1'b0, 16, 1'b0, '0},
    // no command ack, then a long wait before the sensor answers
    '{sht1x_pkg::OpTick,  1'b1, 42, 1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b0, 1,  1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b1, 54, 1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b0, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 2'd1}},
    // new sequence clears the error count
    '{sht1x_pkg::OpHumi,  1'b1, 1,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 8'hFF, 2'd0}},
    '{sht1x_pkg::OpTemp,  1'b0, 24, 1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b0, 1,  1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b0, 54, 1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b1, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd0}},
    // soft reset with a missing ack keeps the stored reading
    '{sht1x_pkg::OpReset, 1'b0, 1,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 8'h00, 2'd0}},
    '{sht1x_pkg::OpTemp,  1'b1, 42, 1'b0, '0},
    '{sht1x_pkg::OpTick,  1'b0, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd1}},
    '{sht1x_pkg::OpTick,  1'b1, 1,  1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 2'd1}}
  };

  sht1x_two_wire_measure_master u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void note_error();
    if (err_q != 2'd3) err_q = err_q + 2'd1;
  endfunction

  // advance the master by one tick and return the line word it reports
  function automatic sht1x_pkg::out_t step_master(sht1x_pkg::in_t w);
    sht1x_pkg::out_t r;
    logic sck;
    logic dat;
    logic done;
    sck  = 1'b0;
    dat  = 1'b1;
    done = 1'b0;
    case (mst_phase)
      MstClrHi: begin
        sck = 1'b1;
        mst_phase = MstClrLo;
      end
      MstClrLo: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'(sht1x_pkg::ResetClocks)) begin
          bit_cnt = '0;
          mst_phase = MstStart;
        end else begin
          mst_phase = MstClrHi;
        end
      end
      MstStart: begin
        sck = StartSck[bit_cnt[2:0]];
        dat = StartDat[bit_cnt[2:0]];
        if (bit_cnt >= 4'd5) begin
          bit_cnt = '0;
          mst_phase = MstTxLo;
        end else begin
          bit_cnt = bit_cnt + 4'd1;
        end
      end
      MstTxLo, MstTxHi: begin
        dat = (bit_cnt < 4'd8) ? shifter[7] : 1'b1;
        if (mst_phase == MstTxLo) begin
          mst_phase = MstTxHi;
        end else begin
          sck = 1'b1;
          if (bit_cnt >= 4'd8) begin
            // command ack sampled on the high tick
            if (w.data_in) note_error();
            bit_cnt = '0;
            wait_cnt = '0;
            mst_phase = (cur_op == sht1x_pkg::OpReset) ? MstEnd : MstWait;
          end else begin
            shifter = {shifter[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            mst_phase = MstTxLo;
          end
        end
      end
      MstWait: begin
        if (!w.data_in) begin
          bit_cnt = '0;
          byte_cnt = '0;
          mst_phase = MstRxLo;
        end else begin
          if (wait_cnt != '1) wait_cnt = wait_cnt + 1'b1;
          if (wait_cnt >= wait_lim || wait_cnt == '1) begin
            note_error();
            bit_cnt = '0;
            byte_cnt = '0;
            mst_phase = MstRxLo;
          end
        end
      end
      MstRxLo, MstRxHi: begin
        // value bytes are acked low, checksum left unacked
        dat = (bit_cnt >= 4'd8) ? (byte_cnt >= 2'd2) : 1'b1;
        if (mst_phase == MstRxLo) begin
          mst_phase = MstRxHi;
        end else begin
          sck = 1'b1;
          if (bit_cnt < 4'd8) begin
            shifter = {shifter[6:0], w.data_in};
            bit_cnt = bit_cnt + 4'd1;
            mst_phase = MstRxLo;
          end else begin
            case (byte_cnt)
              2'd0:    value_q[15:8] = shifter;
              2'd1:    value_q[7:0] = shifter;
              default: check_q = shifter;
            endcase
            bit_cnt = '0;
            if (byte_cnt >= 2'd2) begin
              mst_phase = MstEnd;
            end else begin
              byte_cnt = byte_cnt + 2'd1;
              mst_phase = MstRxLo;
            end
          end
        end
      end
      MstEnd: begin
        done = 1'b1;
        mst_phase = MstIdle;
      end
      default: begin
        mst_phase = MstIdle;
        if (w.opcode != sht1x_pkg::OpTick) begin
          cur_op = w.opcode;
          err_q = '0;
          bit_cnt = '0;
          byte_cnt = '0;
          wait_cnt = '0;
          case (w.opcode)
            sht1x_pkg::OpTemp: shifter = temp_cmd;
            sht1x_pkg::OpHumi: shifter = humi_cmd;
            default:           shifter = rst_cmd;
          endcase
          mst_phase = (w.opcode == sht1x_pkg::OpReset) ? MstClrHi : MstStart;
        end
      end
    endcase
    r.sck_level    = sck;
    r.data_release = dat;
    r.busy_res     = (mst_phase != MstIdle);
    r.done_res     = done;
    r.reading      = value_q;
    r.checksum     = check_q;
    r.error_count  = err_q;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // sensor side of the line for the next tick
  function automatic logic pick_din(bit noisy);
    if (noisy) return 1'($urandom_range(0, 1));
    if (mst_phase == MstTxHi && bit_cnt == 4'd8) return ($urandom_range(0, 9) == 0);
    if (mst_phase == MstWait) begin
      if (wait_left > 0) begin
        wait_left--;
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  // present one word, wait for it to be taken, record its result
  task automatic send_word(input sht1x_pkg::in_t w, output sht1x_pkg::out_t predicted);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_master(w);
    words_sent++;
  endtask

  // hold the sender until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] t, input logic [7:0] h, input logic [7:0] s,
                            input logic [sht1x_pkg::WaitCountBits-1:0] lim);
    logic [1:0]                          idx[4];
    logic [sht1x_pkg::WaitCountBits-1:0] val[4];
    idx = '{sht1x_pkg::CfgTempCmd, sht1x_pkg::CfgHumiCmd, sht1x_pkg::CfgResetCmd,
            sht1x_pkg::CfgWaitLim};
    val = '{{8'h00, t}, {8'h00, h}, {8'h00, s}, lim};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      case (idx[i])
        sht1x_pkg::CfgTempCmd:  temp_cmd = val[i][7:0];
        sht1x_pkg::CfgHumiCmd:  humi_cmd = val[i][7:0];
        sht1x_pkg::CfgResetCmd: rst_cmd = val[i][7:0];
        default:                wait_lim = val[i];
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // result side: check each word taken, then pick the next ready level
  always @(posedge clk_i) begin : result_side
    sht1x_pkg::out_t want;
    sht1x_pkg::out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_word_o;
      results_checked++;
      if (got.done_res) begin
        seqs_done++;
        if (got.error_count != 2'd0) seqs_flagged++;
      end
      if (expected_ticks.size() == 0) begin
        $error("result word taken with nothing expected");
        errors_found++;
      end else begin
        want = expected_ticks.pop_front();
        if (got.sck_level !== want.sck_level) begin
          $error("sck_level: expected %b, got %b", want.sck_level, got.sck_level);
          errors_found++;
        end
        if (got.data_release !== want.data_release) begin
          $error("data_release: expected %b, got %b", want.data_release, got.data_release);
          errors_found++;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res: expected %b, got %b", want.busy_res, got.busy_res);
          errors_found++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %b, got %b", want.done_res, got.done_res);
          errors_found++;
        end
        if (got.reading !== want.reading) begin
          $error("reading: expected %h, got %h", want.reading, got.reading);
          errors_found++;
        end
        if (got.checksum !== want.checksum) begin
          $error("checksum: expected %h, got %h", want.checksum, got.checksum);
          errors_found++;
        end
        if (got.error_count !== want.error_count) begin
          $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
          errors_found++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      stall_left = out_calm ? 0 : pick_gap();
      out_ready_i <= (stall_left == 0);
    end
  end

  // stimulus
  initial begin : stimulus
    sht1x_pkg::in_t                      w;
    sht1x_pkg::out_t                     predicted;
    int                                  budget;
    bit                                  noisy;
    logic [sht1x_pkg::WaitCountBits-1:0] lim;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    foreach (script[i]) begin
      for (int n = 0; n < script[i].reps; n++) begin
        w.opcode  = script[i].op;
        w.data_in = script[i].din;
        send_word(w, predicted);
        expected_ticks.push_back(script[i].known ? script[i].want : predicted);
      end
    end
    drain();

    // random sequences under several register settings
    for (int p = 0; p < NumSettings; p++) begin
      case (p)
        0: set_config(8'h00, 8'h00, 8'h00, '0);
        1: set_config(8'hFF, 8'hFF, 8'hFF, '1);
        2: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(1, 6)));
        3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(7, 40)));
        default: begin
          lim = 16'($urandom_range(0, 65535));
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), lim);
        end
      endcase
      budget = words_sent + RandomWords / NumSettings;
      while (words_sent < budget) begin
        if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
        if ($urandom_range(0, 29) == 0) drain();
        // a few idle ticks between sequences
        repeat ($urandom_range(0, 3)) begin
          w.opcode  = sht1x_pkg::OpTick;
          w.data_in = 1'($urandom_range(0, 1));
          send_word(w, predicted);
          expected_ticks.push_back(predicted);
        end
        noisy = ($urandom_range(0, 99) < 15);
        wait_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 60);
        w.opcode  = 2'($urandom_range(1, 3));
        w.data_in = 1'($urandom_range(0, 1));
        send_word(w, predicted);
        expected_ticks.push_back(predicted);
        while (mst_phase != MstIdle) begin
          w.opcode  = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                                  : sht1x_pkg::OpTick;
          w.data_in = pick_din(noisy);
          send_word(w, predicted);
          expected_ticks.push_back(predicted);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d words sent, %0d results checked", words_sent, results_checked);
    $display("%0d sequences finished, %0d with errors flagged, %0d register settings",
             seqs_done, seqs_flagged, NumSettings + 1);
    if (errors_found == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sht1x_pkg.sv
rtl/sht1x_seq.sv
rtl/sht1x_two_wire_measure_master.sv
tb/sv/testbench.sv
